FILE: hdl/dq_pkg.sv
// Shared constants, request and status codes, and controller command type for the deque.
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;

    localparam int S_FIELDS_W = REQ_W + DATA_WIDTH;
    localparam int M_FIELDS_W = DATA_WIDTH + STATUS_W + 1 + CNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic capture;   // take the input beat and launch the slot read
        logic commit;    // apply the request and load the result register
    } dq_cmd_t;

    // Fold a position below 2*DEPTH back into the ring.
    function automatic logic [ADDR_W-1:0] ring_wrap(input logic [ADDR_W:0] pos);
        logic [ADDR_W:0] folded;
        folded = pos;
        if (pos >= (ADDR_W + 1)'(DEPTH)) begin
            folded = pos - (ADDR_W + 1)'(DEPTH);
        end
        return folded[ADDR_W-1:0];
    endfunction

endpackage

FILE: hdl/dq_ctrl.sv
// Controller: request sequencing and result handshake for the deque.
module dq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output dq_pkg::dq_cmd_t cmd
);
    import dq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.capture = s_tvalid && s_tready;
    // Commit only when the result register is free or drains this cycle.
    assign cmd.commit  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/dq_datapath.sv
// Datapath: slot memory, ring pointers and result register of the deque.
module dq_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dq_pkg::dq_cmd_t              cmd,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];

    logic [REQ_W-1:0]      req_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [REQ_W-1:0]      in_req;
    logic [DATA_WIDTH-1:0] in_word;
    logic [ADDR_W-1:0]     front_addr, rear_addr, tail_addr, rd_addr;
    logic [ADDR_W-1:0]     head_dec, head_inc;
    logic                  q_empty, is_full;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [STATUS_W-1:0]   status;

    assign in_req  = s_tdata[REQ_W-1:0];
    assign in_word = s_tdata[REQ_W +: DATA_WIDTH];

    assign q_empty = (count_reg == '0);
    assign is_full = (count_reg >= CNT_W'(DEPTH));

    assign front_addr = head_reg;
    // tail_addr is the first free slot; rear_addr the last live one
    assign tail_addr  = ring_wrap({1'b0, head_reg} + (ADDR_W + 1)'(count_reg));
    assign rear_addr  = q_empty ? head_reg
                      : ring_wrap({1'b0, head_reg} + (ADDR_W + 1)'(count_reg)
                                  - (ADDR_W + 1)'(1));
    assign head_dec   = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign head_inc   = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);

    always_comb begin
        case (in_req)
            REQ_POP_REAR, REQ_PEEK_REAR: rd_addr = rear_addr;
            default:                     rd_addr = front_addr;
        endcase
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_addr;
        rd_value   = '0;
        status     = STAT_OK;
        case (req_reg)
            REQ_PUSH_REAR: begin
                if (is_full) begin
                    status = STAT_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    status = STAT_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_REAR, REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_PEEK_REAR: begin
                if (q_empty) begin
                    rd_value = '1;
                    status   = STAT_EMPTY;
                end else begin
                    rd_value = rd_data_reg;
                    if (req_reg == REQ_POP_REAR) begin
                        count_next = count_reg - CNT_W'(1);
                    end else if (req_reg == REQ_POP_FRONT) begin
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg     <= in_req;
            word_reg    <= in_word;
            rd_data_reg <= slot_mem[rd_addr];
        end
        if (cmd.commit && wr_en) begin
            slot_mem[wr_addr] <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.commit) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= M_TDATA_W'({count_next, (count_next == '0), status, rd_value});
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

FILE: hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue: controller plus datapath.
//
//   channel | direction | beat contents
//   s_      | in        | tdata: req_type[2:0], push_value[34:3], zero fill to 40 bits
//   m_      | out       | tdata: read_value[31:0], status[33:32], now_empty[34],
//           |           |        fill_count[39:35]
//
// A request is captured on the input beat, which launches the slot read, and is then
// applied, with its result registered, in the execute state (one memory port).
// The result register lets the next request be taken while a result waits; a stalled
// result holds the request in the execute state until the register frees up.
// Synchronous reset empties the queue; slot contents are not cleared.
module double_ended_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,   // req_type, push_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0] m_tdata    // read_value, status, now_empty, fill_count
);
    import dq_pkg::*;

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
